// ===== rtl/core/pecr_pkg.sv =====
// Shared types and constants for the per-id event counter.
// Used by pecr_count_ram, pecr_update and per_id_event_counter_pow2_report.
// No dependencies.
package pecr_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 65536;
	localparam int COUNT_WIDTH = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Field widths
	localparam int ID_W      = 32;
	localparam int EV_W      = 12;
	localparam int TIME_W    = 64;
	localparam int RPT_CNT_W = 32;
	localparam int CFG_W     = 32;
	localparam int CMP_W     = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	// Stream data widths, padded to whole bytes
	localparam int IN_FIELDS_W  = ID_W + EV_W + TIME_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = ID_W + EV_W + RPT_CNT_W + TIME_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t             COUNT_MAX = '1;
	localparam addr_t              LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [ID_W-1:0]    DEPTH_ID  = ID_W'(TABLE_DEPTH);
	localparam logic [CFG_W-1:0]   MIN_RESET = CFG_W'(64);

	// Write port into the counter memory
	typedef struct packed {
		logic   en;
		addr_t  addr;
		count_t data;
	} wr_port_t;

	// One report, as it leaves the update stage
	typedef struct packed {
		logic [TIME_W-1:0]    time_ns;
		logic [RPT_CNT_W-1:0] count;
		logic [EV_W-1:0]      event_number;
		logic [ID_W-1:0]      proc_id;
	} report_t;

endpackage

// ===== rtl/core/pecr_count_ram.sv =====
// Counter table: one synchronous memory, one write and one read port,
// registered read data, plus the clearing sweep that zeroes it after reset.
// Depends on pecr_pkg.
module pecr_count_ram (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  pecr_pkg::addr_t  rd_addr,
	output pecr_pkg::count_t rd_data,
	input  pecr_pkg::wr_port_t wr,
	output logic             clearing
);
	import pecr_pkg::*;

	count_t mem [TABLE_DEPTH];
	count_t rd_data_q;
	logic   clearing_q;
	addr_t  clr_addr_q;

	logic   mem_we;
	addr_t  mem_wa;
	count_t mem_wd;

	// Sweep owns the write port until the last entry is cleared
	assign mem_we = clearing_q | wr.en;
	assign mem_wa = clearing_q ? clr_addr_q : wr.addr;
	assign mem_wd = clearing_q ? '0 : wr.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Memory array; read during write of the same entry returns old data
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== rtl/core/pecr_update.sv =====
// Update stage: takes the read counter, forwards the last written value,
// increments with saturation, writes back and decides on a report.
// Depends on pecr_pkg.
module pecr_update (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [pecr_pkg::ID_W-1:0]   proc_id,
	input  logic [pecr_pkg::EV_W-1:0]   event_number,
	input  logic [pecr_pkg::TIME_W-1:0] time_ns,
	input  pecr_pkg::count_t            rd_data,
	input  logic [pecr_pkg::CFG_W-1:0]  min_count,
	input  logic                       out_free,
	output logic                       stall,
	output pecr_pkg::wr_port_t          wr,
	output logic                       rpt_valid,
	output pecr_pkg::report_t           rpt
);
	import pecr_pkg::*;

	logic              valid_s1;
	addr_t             addr_s1;
	logic [ID_W-1:0]   id_s1;
	logic [EV_W-1:0]   ev_s1;
	logic [TIME_W-1:0] time_s1;

	logic              fwd_valid_q;
	addr_t             fwd_addr_q;
	count_t            fwd_count_q;

	count_t cur_count;
	count_t nxt_count;
	logic   is_pow2;
	logic   above_min;
	logic   report;
	logic   retire;

	// Memory read was issued before the last write landed: take the newer value
	assign cur_count = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_count_q : rd_data;
	assign nxt_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
	assign is_pow2   = (nxt_count != '0) && ((nxt_count & (nxt_count - 1'b1)) == '0);
	assign above_min = CMP_W'(nxt_count) >= CMP_W'(min_count);
	assign report    = valid_s1 && is_pow2 && above_min;
	assign stall     = report && !out_free;
	assign retire    = valid_s1 && !stall;

	// Stage register; out-of-range ids never enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (proc_id < DEPTH_ID);
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= ADDR_W'(proc_id);
			id_s1   <= proc_id;
			ev_s1   <= event_number;
			time_s1 <= time_ns;
		end
	end

	// Last write back, for forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (retire) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			fwd_addr_q  <= addr_s1;
			fwd_count_q <= nxt_count;
		end
	end

	assign wr.en   = retire;
	assign wr.addr = addr_s1;
	assign wr.data = nxt_count;

	assign rpt_valid        = report && out_free;
	assign rpt.proc_id      = id_s1;
	assign rpt.event_number = ev_s1;
	assign rpt.count        = RPT_CNT_W'(nxt_count);
	assign rpt.time_ns      = time_s1;

endmodule

// ===== rtl/core/per_id_event_counter_pow2_report.sv =====
// Per-id event counter with power-of-two reports. Each input transaction is
// one event; an id below 65536 bumps its 32-bit counter (saturating), and
// when the new count is a power of two not below min_report_count a report
// transaction is sent. Ids of 65536 and above are dropped silently. After
// reset the counter memory is cleared, one entry a cycle, during which
// s_axis_tready stays low; configuration writes are taken at any time. After
// that one event is taken each cycle: a memory read stage and an update
// stage with forwarding from the last write back, so repeated
// ids run back to back. A result waits in an output register; input only
// stalls when a report is due and that register is still full.
// Depends on pecr_pkg, pecr_count_ram and pecr_update.
module per_id_event_counter_pow2_report (
	input  logic                              clk,
	input  logic                              arst_n,
	// proc_id[31:0], event_number[43:32], time_ns[107:44], zero pad
	input  logic [pecr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// report_id[31:0], report_event[43:32], report_count[75:44],
	// report_time[139:76], zero pad
	output logic [pecr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// min_report_count
	input  logic [pecr_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready
);
	import pecr_pkg::*;

	logic [CFG_W-1:0] min_count_q;
	logic             clearing;
	logic             stall;
	logic             accept;
	logic             out_free;
	count_t           rd_data;
	wr_port_t         wr;
	logic             rpt_valid;
	report_t          rpt;

	logic             out_valid_q;
	report_t          out_q;

	logic [ID_W-1:0]   in_id;
	logic [EV_W-1:0]   in_ev;
	logic [TIME_W-1:0] in_time;

	// Unpack input transaction
	assign in_id   = s_axis_tdata[ID_W-1:0];
	assign in_ev   = s_axis_tdata[ID_W +: EV_W];
	assign in_time = s_axis_tdata[ID_W+EV_W +: TIME_W];

	assign s_axis_tready = !clearing && !stall;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= MIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_count_q <= cfg_data;
		end
	end

	pecr_count_ram u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (ADDR_W'(in_id)),
		.rd_data  (rd_data),
		.wr       (wr),
		.clearing (clearing)
	);

	pecr_update u_update (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.proc_id      (in_id),
		.event_number (in_ev),
		.time_ns      (in_time),
		.rd_data      (rd_data),
		.min_count    (min_count_q),
		.out_free     (out_free),
		.stall        (stall),
		.wr           (wr),
		.rpt_valid    (rpt_valid),
		.rpt          (rpt)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rpt_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_valid) begin
			out_q <= rpt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_q.time_ns, out_q.count,
		out_q.event_number, out_q.proc_id});

endmodule

// ===== verif/per_id_event_counter_pow2_report_test.sv =====
// Self-checking testbench for per_id_event_counter_pow2_report: drives event
// transactions, predicts the power-of-two reports and checks each one.
// Depends on pecr_pkg and the per_id_event_counter_pow2_report RTL.
module per_id_event_counter_pow2_report_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pecr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 160;
	localparam int SETTLE_CYC  = 8;

	// One event as it travels in s_axis_tdata, proc_id in the lowest bits
	typedef struct packed {
		logic [TIME_W-1:0] time_ns;
		logic [EV_W-1:0]   event_number;
		logic [ID_W-1:0]   proc_id;
	} obs_t;

	typedef struct {
		obs_t obs;
		bit   drain;
	} queued_obs_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	// proc_id, event_number, time_ns, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// report_id, report_event, report_count, report_time, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;

	// Predictor state: one counter per id and the current report threshold
	bit [COUNT_WIDTH-1:0]  tally [TABLE_DEPTH];
	logic [CFG_W-1:0]      min_count = MIN_RESET;

	queued_obs_t           pend_q[$];
	report_t               report_q[$];
	obs_t                  held_obs;
	int                    send_gap = 0;
	int                    recv_gap = 0;
	int                    fail_cnt = 0;
	int                    cycle_cnt = 0;
	bit                    calm = 1'b1;

	per_id_event_counter_pow2_report dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_data      (cfg_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle length: none while calm; else mostly none, some short, a few long
	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic log_fault(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s", msg);
	endtask

	// Count one accepted event and queue the report it should raise
	task automatic count_event(input obs_t o);
		logic [COUNT_WIDTH-1:0] c;
		report_t                r;
		if (o.proc_id >= DEPTH_ID)
			return;
		c = tally[o.proc_id[ADDR_W-1:0]];
		if (c != COUNT_MAX)
			c = c + 1'b1;
		tally[o.proc_id[ADDR_W-1:0]] = c;
		if (c != '0 && (c & (c - 1'b1)) == '0 && CMP_W'(c) >= CMP_W'(min_count)) begin
			r.proc_id      = o.proc_id;
			r.event_number = o.event_number;
			r.count        = RPT_CNT_W'(c);
			r.time_ns      = o.time_ns;
			report_q.push_back(r);
		end
	endtask

	task automatic queue_obs(input logic [ID_W-1:0] id, input logic [EV_W-1:0] ev,
			input logic [TIME_W-1:0] t, input bit drain);
		queued_obs_t q;
		q.obs.proc_id      = id;
		q.obs.event_number = ev;
		q.obs.time_ns      = t;
		q.drain            = drain;
		pend_q.push_back(q);
	endtask

	// Random id: hot ids to climb the powers of two, ids at the table edge, the rest spread wide
	function automatic logic [ID_W-1:0] pick_id();
		int unsigned     r;
		logic [ID_W-1:0] id;
		r = $urandom_range(0, 99);
		if (r < 55)
			id = $urandom_range(0, 3);
		else if (r < 60)
			id = DEPTH_ID - 1;
		else if (r < 82)
			id = $urandom_range(0, TABLE_DEPTH - 1);
		else if (r < 95) begin
			id = $urandom;
			if (id < DEPTH_ID)
				id = id + DEPTH_ID;
		end else
			id = DEPTH_ID;
		return id;
	endfunction

	// Threshold write; only issued while the block is quiet
	task automatic write_min(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		min_count = v;
		cfg_valid <= 1'b0;
	endtask

	// Wait until nothing is queued, in flight or outstanding; looked at
	// just after the edge so that driver and monitor updates have landed
	task automatic settle();
		do begin
			@(posedge clk);
			#1;
		end while (pend_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Event driver
	always @(posedge clk) begin
		queued_obs_t q;
		logic        drive_v;
		drive_v = s_axis_tvalid;
		if (s_axis_tvalid && s_axis_tready) begin
			count_event(held_obs);
			drive_v  = 1'b0;
			send_gap = idle_len();
		end
		if (!drive_v) begin
			if (send_gap > 0)
				send_gap--;
			else if (pend_q.size() != 0 && !(pend_q[0].drain && report_q.size() != 0)) begin
				q            = pend_q.pop_front();
				held_obs     = q.obs;
				drive_v      = 1'b1;
				s_axis_tdata <= IN_DATA_W'(q.obs);
			end
		end
		s_axis_tvalid <= drive_v;
	end

	// Report monitor and receiver stalls
	always @(posedge clk) begin
		report_t got;
		report_t want;
		bit      hs;
		hs = m_axis_tvalid && m_axis_tready;
		if (hs) begin
			got = report_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
			if (report_q.size() == 0)
				log_fault($sformatf("unexpected report: id %0h ev %0h count %0h time %0h",
					got.proc_id, got.event_number, got.count, got.time_ns));
			else begin
				want = report_q.pop_front();
				if (got.proc_id !== want.proc_id || got.event_number !== want.event_number ||
						got.count !== want.count || got.time_ns !== want.time_ns)
					log_fault({$sformatf(
						"report mismatch: exp id %0h ev %0h count %0h time %0h",
						want.proc_id, want.event_number, want.count, want.time_ns),
						$sformatf(", got id %0h ev %0h count %0h time %0h",
						got.proc_id, got.event_number, got.count, got.time_ns)});
			end
		end
		if (recv_gap > 0)
			recv_gap--;
		else if (hs || $urandom_range(0, 7) == 0)
			recv_gap = idle_len();
		m_axis_tready <= (recv_gap == 0);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		logic [CFG_W-1:0] phase_min [PHASES];
		phase_min[0] = 32'd1;
		phase_min[1] = 32'h8000_0000;
		phase_min[2] = 32'd64;
		phase_min[3] = 32'd7;
		phase_min[4] = 32'd2;
		phase_min[5] = 32'd1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: zero threshold acts as one, field extremes, ids at the edge
		calm = 1'b1;
		write_min('0);
		queue_obs(32'd0, 12'h000, 64'h0, 1'b0);
		queue_obs(32'd0, 12'hfff, '1, 1'b0);
		queue_obs(32'd0, 12'h555, 64'h5555_5555_5555_5555, 1'b0);
		queue_obs(DEPTH_ID - 1, 12'haaa, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		queue_obs(DEPTH_ID, 12'h123, 64'h1, 1'b0);
		queue_obs(32'hffff_ffff, 12'hfff, '1, 1'b0);
		queue_obs(32'h8000_0000, 12'h000, 64'h0, 1'b0);
		queue_obs(DEPTH_ID - 1, 12'h001, 64'h8000_0000_0000_0000, 1'b0);
		queue_obs(32'd0, 12'h800, 64'h0123_4567_89ab_cdef, 1'b0);
		settle();

		// Threshold that is not a power of two: next report at eight
		write_min(32'd5);
		for (int i = 0; i < 5; i++)
			queue_obs(32'd0, EV_W'(i), TIME_W'(i), 1'b0);
		for (int i = 0; i < 8; i++)
			queue_obs(32'd9, EV_W'(i + 16), {$urandom, $urandom}, 1'b0);
		settle();

		// Random phases, each under its own threshold
		for (int p = 0; p < PHASES; p++) begin
			write_min(phase_min[p]);
			calm = (p == 1 || p == 4);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_obs(pick_id(), EV_W'($urandom_range(0, 4095)), {$urandom, $urandom},
					i == PHASE_ITEMS / 2);
			settle();
		end

		while (report_q.size() != 0) begin
			want_left(report_q.pop_front());
		end
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	task automatic want_left(input report_t r);
		log_fault($sformatf("missing report: id %0h ev %0h count %0h time %0h",
			r.proc_id, r.event_number, r.count, r.time_ns));
	endtask

endmodule
